[design/srrd_pkg.sv]
package srrd_pkg;

	// Register reset values
	localparam logic [7:0] SLOW_PERIOD_RST = 8'd15;
	localparam logic [7:0] FAST_PERIOD_RST = 8'd2;
	localparam logic [7:0] DWELL_STEPS_RST = 8'd20;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_SLOW_PERIOD = 2'd0,
		REG_FAST_PERIOD = 2'd1,
		REG_DWELL_STEPS = 2'd2
	} reg_idx_t;

	// Full-step coil patterns by phase
	localparam logic [3:0] COIL_PH0 = 4'd9;
	localparam logic [3:0] COIL_PH1 = 4'd10;
	localparam logic [3:0] COIL_PH2 = 4'd6;
	localparam logic [3:0] COIL_PH3 = 4'd5;

	typedef struct packed {
		logic [7:0] slow_period;
		logic [7:0] fast_period;
		logic [7:0] dwell_steps;
	} srrd_cfg_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [7:0] ticks;
		logic [7:0] period;
		logic [7:0] dwell;
		logic       dir_rev;
		logic       ramp_up;
		logic       run;
		logic       btn_prev;
		logic [3:0] coil;
	} srrd_state_t;

	function automatic logic [3:0] coil_pattern(input logic [1:0] ph);
		logic [3:0] pat;
		case (ph)
			2'd0:    pat = COIL_PH0;
			2'd1:    pat = COIL_PH1;
			2'd2:    pat = COIL_PH2;
			default: pat = COIL_PH3;
		endcase
		return pat;
	endfunction

	// One phase forward, or one back when reversed
	function automatic logic [1:0] next_phase(input logic [1:0] ph, input logic rev);
		return rev ? ph - 2'd1 : ph + 2'd1;
	endfunction

endpackage

[design/srrd_if.sv]
interface srrd_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic button_level;

	modport source (output valid, output req_type, output button_level, input ready);
	modport sink   (input valid, input req_type, input button_level, output ready);
endinterface

interface srrd_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] coil_drive;
	logic       running;
	logic       reverse_dir;
	logic [7:0] step_period;
	logic       accelerating;

	modport source (output valid, output coil_drive, output running, output reverse_dir,
		output step_period, output accelerating, input ready);
	modport sink   (input valid, input coil_drive, input running, input reverse_dir,
		input step_period, input accelerating, output ready);
endinterface

[design/stepper_ramp_reversing_driver.sv]
// Channel  Dir  Payload                                                  Type
// req_ch   in   req_type, button_level                                   srrd_req_if.sink
// res_ch   out  coil_drive, running, reverse_dir, step_period, accel.    srrd_res_if.source
// cfg      in   cfg_we, cfg_index, cfg_data                              plain write port
//
// One transaction per cycle sustained while res_ch accepts results.
// The input register feeds the step logic, which updates the motor state and loads
// the result register in the same cycle. Results come out one per request, in order.
// A stall on res_ch holds the result register and backs up through the input stage.
// arst_n clears state to the stopped, forward, ramp-up condition at slow period 15.
module stepper_ramp_reversing_driver
	import srrd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	srrd_req_if.sink   req_ch,
	srrd_res_if.source res_ch,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	srrd_cfg_t   cfg_q;
	srrd_state_t state_q;
	srrd_state_t state_nxt;
	logic        valid_s1;
	logic        req_type_s1;
	logic        button_level_s1;
	logic        out_valid_q;
	logic        advance;

	assign advance      = valid_s1 && (!out_valid_q || res_ch.ready);
	assign req_ch.ready = !valid_s1 || advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow_period <= SLOW_PERIOD_RST;
			cfg_q.fast_period <= FAST_PERIOD_RST;
			cfg_q.dwell_steps <= DWELL_STEPS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOW_PERIOD: cfg_q.slow_period <= cfg_data;
				REG_FAST_PERIOD: cfg_q.fast_period <= cfg_data;
				REG_DWELL_STEPS: cfg_q.dwell_steps <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ch.ready) begin
			valid_s1 <= req_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			req_type_s1     <= req_ch.req_type;
			button_level_s1 <= req_ch.button_level;
		end
	end

	srrd_step u_step (
		.cfg          (cfg_q),
		.cur          (state_q),
		.req_type     (req_type_s1),
		.button_level (button_level_s1),
		.nxt          (state_nxt)
	);

	// Motor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase    <= 2'd0;
			state_q.ticks    <= 8'd0;
			state_q.period   <= SLOW_PERIOD_RST;
			state_q.dwell    <= 8'd0;
			state_q.dir_rev  <= 1'b0;
			state_q.ramp_up  <= 1'b1;
			state_q.run      <= 1'b0;
			state_q.btn_prev <= 1'b0;
			state_q.coil     <= 4'd0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_ch.coil_drive   <= state_nxt.coil;
			res_ch.running      <= state_nxt.run;
			res_ch.reverse_dir  <= state_nxt.dir_rev;
			res_ch.step_period  <= state_nxt.period;
			res_ch.accelerating <= state_nxt.ramp_up;
		end
	end

	assign res_ch.valid = out_valid_q;

endmodule

[design/srrd_step.sv]
module srrd_step
	import srrd_pkg::*;
(
	input  srrd_cfg_t   cfg,
	input  srrd_state_t cur,
	input  logic        req_type,
	input  logic        button_level,
	output srrd_state_t nxt
);

	logic [7:0] slow_eff;
	logic [7:0] fast_eff;
	logic [7:0] tick_inc;
	logic [7:0] dwell_b;
	logic [1:0] ph1;
	logic [1:0] ph2;
	logic       go_down;

	// Zero period registers act as one
	assign slow_eff = (cfg.slow_period == 8'd0) ? 8'd1 : cfg.slow_period;
	assign fast_eff = (cfg.fast_period == 8'd0) ? 8'd1 : cfg.fast_period;
	assign tick_inc = (cur.ticks == 8'hFF) ? 8'hFF : cur.ticks + 8'd1;
	assign ph1      = next_phase(cur.phase, cur.dir_rev);
	assign ph2      = next_phase(ph1, ~cur.dir_rev);

	always_comb begin
		nxt     = cur;
		go_down = 1'b0;
		dwell_b = cur.dwell;
		if (req_type) begin
			// button rising edge toggles run; stopping blanks the coils and resets direction, ramp and dwell
			if (button_level && !cur.btn_prev) begin
				if (cur.run) begin
					nxt.run     = 1'b0;
					nxt.coil    = 4'd0;
					nxt.dir_rev = 1'b0;
					nxt.ramp_up = 1'b1;
					nxt.dwell   = 8'd0;
				end else begin
					nxt.run = 1'b1;
				end
			end
			nxt.btn_prev = button_level;
		end else if (cur.run) begin
			nxt.ticks = tick_inc;
			if (tick_inc >= cur.period) begin
				nxt.ticks = 8'd0;
				nxt.phase = ph1;
				// ramp up, then dwell, then turn to ramp down
				if (cur.ramp_up) begin
					if (cur.period > fast_eff) begin
						nxt.period = cur.period - 8'd1;
					end else if (cur.dwell < cfg.dwell_steps) begin
						nxt.dwell = cur.dwell + 8'd1;
					end else begin
						go_down     = 1'b1;
						dwell_b     = 8'd0;
						nxt.ramp_up = 1'b0;
						nxt.dwell   = 8'd0;
					end
				end else begin
					go_down = 1'b1;
				end
				// ramp down, reversing at the slow period
				if (go_down) begin
					if (cur.period < slow_eff) begin
						nxt.period = cur.period + 8'd1;
					end else begin
						nxt.dir_rev = ~cur.dir_rev;
						nxt.phase   = ph2;
						nxt.period  = slow_eff;
						nxt.ramp_up = 1'b1;
						nxt.dwell   = dwell_b;
						// the reversal step also takes one ramp-up step
						if (slow_eff > fast_eff) begin
							nxt.period = slow_eff - 8'd1;
						end else if (dwell_b < cfg.dwell_steps) begin
							nxt.dwell = dwell_b + 8'd1;
						end else begin
							nxt.ramp_up = 1'b0;
							nxt.dwell   = 8'd0;
						end
					end
				end
				nxt.coil = coil_pattern(nxt.phase);
			end
		end
	end

endmodule

[design/srrd_checker.sv]
module srrd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [3:0] coil_drive,
	input logic       running,
	input logic       reverse_dir,
	input logic [7:0] step_period,
	input logic       accelerating
);

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(coil_drive) && $stable(running)
			&& $stable(reverse_dir) && $stable(step_period) && $stable(accelerating))
		else $error("result changed while stalled");

	// Coils stay blank while stopped
	a_stop_blank: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !running |-> coil_drive == 4'd0)
		else $error("coils driven while stopped");

	// Stopped motor sits forward in ramp up
	a_stop_dir: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !running |-> !reverse_dir && accelerating)
		else $error("direction or ramp not reset while stopped");

	// Only full-step patterns or blank
	a_coil_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> coil_drive == 4'd0 || coil_drive == 4'd9 || coil_drive == 4'd10
			|| coil_drive == 4'd6 || coil_drive == 4'd5)
		else $error("illegal coil pattern");

	// Period never reaches zero
	a_period_nz: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> step_period != 8'd0)
		else $error("zero step period");

endmodule

bind stepper_ramp_reversing_driver srrd_checker u_srrd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res_ch.valid),
	.res_ready    (res_ch.ready),
	.coil_drive   (res_ch.coil_drive),
	.running      (res_ch.running),
	.reverse_dir  (res_ch.reverse_dir),
	.step_period  (res_ch.step_period),
	.accelerating (res_ch.accelerating)
);
